[hw/rtl/drrm_pkg.sv]
// Shared constants, types and arithmetic helpers for the direction/roll rotation matrix block.
`default_nettype none

package drrm_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int DATA_W        = 32;
   localparam int FRAC_BITS     = 30;
   localparam int THR_W         = 31;
   localparam int ANG_W         = 32;
   localparam int VEC_W         = 36;
   localparam int ROT_W         = 34;
   localparam int MUL_W         = 34;
   localparam int PRD_W         = 38;
   localparam int GAIN_W        = 30;
   localparam int MAT_W         = 9 * DATA_W;
   localparam int IN_W          = 4 * DATA_W;

   localparam logic signed [DATA_W-1:0] ONE_Q      = 32'sh4000_0000;
   localparam logic [GAIN_W-1:0]        GAIN_Q     = 30'h26DD_3B6A;
   localparam logic [ANG_W-1:0]         HALF_TURN    = 32'h8000_0000;
   localparam logic [ANG_W-1:0]         QUARTER_TURN = 32'h4000_0000;
   localparam logic [THR_W-1:0]         THR_RESET  = 31'h4000_0000;

   typedef struct packed {
      logic                     pole;
      logic signed [DATA_W-1:0] ct;
      logic [ANG_W-1:0]         roll;
   } side_type;

   // atan(2^-i) as a binary angle, zero past the table
   function automatic logic [ANG_W-1:0] atan_at(input int i);
      logic [ANG_W-1:0] r;
      case (i)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         30: r = 32'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // fixed-point product, rounded to nearest with ties away from zero
   function automatic logic signed [PRD_W-1:0] mulq(input logic signed [MUL_W-1:0] a,
                                                     input logic signed [MUL_W-1:0] b);
      logic [MUL_W-1:0]   ua;
      logic [MUL_W-1:0]   ub;
      logic [2*MUL_W-1:0] p;
      logic [2*MUL_W-1:0] r;
      ua = a[MUL_W-1] ? $unsigned(-a) : $unsigned(a);
      ub = b[MUL_W-1] ? $unsigned(-b) : $unsigned(b);
      p  = ua * ub;
      r  = (p + ((2*MUL_W)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
      return (a[MUL_W-1] ^ b[MUL_W-1]) ? -$signed(PRD_W'(r)) : $signed(PRD_W'(r));
   endfunction

   // clamp to [-1.0, 1.0] in Q2.30
   function automatic logic signed [DATA_W-1:0] sat_q30(input logic signed [PRD_W:0] v);
      logic signed [PRD_W:0]    lim;
      logic signed [DATA_W-1:0] r;
      lim = (PRD_W+1)'(ONE_Q);
      if (v > lim) begin
         r = ONE_Q;
      end else if (v < -lim) begin
         r = -ONE_Q;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/direction_roll_rotation_matrix.sv]
// Throughput: one word per cycle unless rsp_tready stalls; the vectoring CORDIC (32 stages)
// feeds two parallel rotation CORDICs (32 stages), then three product/sum stages, all behind
// one global stall. A one-word skid at the input accepts a word while a result waits on
// rsp_tready; req_tready is low while the skid holds that word.
// Reset (synchronous, active high) empties the pipeline and sets pole_threshold to 1.0.
`default_nettype none

module direction_roll_rotation_matrix
   import drrm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [IN_W-1:0]   req_tdata,   // dir_x, dir_y, dir_z, roll_angle
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [MAT_W-1:0]       rsp_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   input  wire logic              csr_we,
   input  wire logic [THR_W-1:0]  csr_wdata
);

   localparam int RD = CORDIC_STAGES + 1;

   logic [THR_W-1:0]         thr_ff;
   logic                     skid_vld_ff;
   logic [IN_W-1:0]          skid_data_ff;

   logic                     en;
   logic                     take;
   logic                     src_valid;
   logic [IN_W-1:0]          src_data;
   logic signed [DATA_W-1:0] src_x, src_y, src_z;
   logic signed [DATA_W:0]   az;
   side_type                 side_in;

   logic                     vec_valid;
   logic [ANG_W-1:0]         vec_ang;
   logic signed [MUL_W-1:0]  vec_mag;
   side_type                 vec_side;

   logic [RD-1:0]            dly_vld_ff;
   side_type                 dly_side_ff [RD];
   logic signed [MUL_W-1:0]  dly_mag_ff  [RD];

   logic signed [DATA_W-1:0] phi_cos, phi_sin, roll_cos, roll_sin;
   logic signed [DATA_W-1:0] cp, sp;
   logic signed [MUL_W-1:0]  st;
   side_type                 side_end;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = !skid_vld_ff;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // hold a word that arrives during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         skid_vld_ff <= 1'b0;
      end else if (take) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && take) begin
         skid_data_ff <= req_tdata;
      end
   end

   assign src_valid = skid_vld_ff || take;
   assign src_data  = skid_vld_ff ? skid_data_ff : req_tdata;
   assign src_x     = $signed(src_data[0*DATA_W +: DATA_W]);
   assign src_y     = $signed(src_data[1*DATA_W +: DATA_W]);
   assign src_z     = $signed(src_data[2*DATA_W +: DATA_W]);
   assign az        = src_z[DATA_W-1] ? -(DATA_W+1)'(src_z) : (DATA_W+1)'(src_z);

   always_comb begin
      side_in.pole = az >= $signed({2'b00, thr_ff});
      side_in.roll = src_data[3*DATA_W +: DATA_W];
      if (side_in.pole) begin
         side_in.ct = src_z[DATA_W-1] ? -ONE_Q : ONE_Q;
      end else begin
         side_in.ct = src_z;
      end
   end

   drrm_vec_cordic u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (src_valid),
      .in_x      (src_x),
      .in_y      (src_y),
      .in_side   (side_in),
      .out_valid (vec_valid),
      .out_ang   (vec_ang),
      .out_mag   (vec_mag),
      .out_side  (vec_side)
   );

   drrm_rot_cordic u_phi (
      .clock   (clock),
      .en      (en),
      .in_ang  (vec_ang),
      .out_cos (phi_cos),
      .out_sin (phi_sin)
   );

   drrm_rot_cordic u_roll (
      .clock   (clock),
      .en      (en),
      .in_ang  (vec_side.roll),
      .out_cos (roll_cos),
      .out_sin (roll_sin)
   );

   // align side data with the rotation CORDIC outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else if (en) begin
         dly_vld_ff <= {dly_vld_ff[RD-2:0], vec_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_side_ff[0] <= vec_side;
         dly_mag_ff[0]  <= vec_mag;
         for (int i = 1; i < RD; i++) begin
            dly_side_ff[i] <= dly_side_ff[i-1];
            dly_mag_ff[i]  <= dly_mag_ff[i-1];
         end
      end
   end

   assign side_end = dly_side_ff[RD-1];
   assign cp       = side_end.pole ? ONE_Q : phi_cos;
   assign sp       = side_end.pole ? '0 : phi_sin;
   assign st       = side_end.pole ? '0 : dly_mag_ff[RD-1];

   drrm_mat u_mat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dly_vld_ff[RD-1]),
      .in_cp     (cp),
      .in_sp     (sp),
      .in_st     (st),
      .in_ct     (side_end.ct),
      .in_co     (roll_cos),
      .in_so     (roll_sin),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && en) |=> !skid_vld_ff)
      else $error("skid word not drained on advance");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vec_valid) && $stable(dly_vld_ff))
      else $error("pipeline valid moved during stall");

   a_m22_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[8*DATA_W +: DATA_W]) <= ONE_Q) &&
                     ($signed(rsp_tdata[8*DATA_W +: DATA_W]) >= -ONE_Q))
      else $error("m22 outside saturation range");

endmodule

`default_nettype wire

[hw/rtl/drrm_vec_cordic.sv]
// Vectoring CORDIC pipeline: angle and magnitude of (x, y), with side data carried along.
`default_nettype none

module drrm_vec_cordic
   import drrm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [DATA_W-1:0] in_x,
   input  wire logic signed [DATA_W-1:0] in_y,
   input  wire side_type                 in_side,
   output logic                          out_valid,
   output logic [ANG_W-1:0]              out_ang,
   output logic signed [MUL_W-1:0]       out_mag,
   output side_type                      out_side
);

   localparam int N = CORDIC_STAGES;
   localparam int PW = VEC_W - 1 + GAIN_W;

   logic [N:0]                vld_ff;
   logic                      zero_ff [N+1];
   side_type                  side_ff [N+1];
   logic signed [VEC_W-1:0]   x_ff    [N+1];
   logic signed [VEC_W-1:0]   y_ff    [N+1];
   logic [ANG_W-1:0]          z_ff    [N+1];

   logic signed [VEC_W-1:0]   xe_in;
   logic signed [VEC_W-1:0]   ye_in;
   logic [PW-1:0]             mag_prod;
   logic signed [MUL_W-1:0]   mag_in;

   logic                      vld_out_ff;
   logic [ANG_W-1:0]          ang_ff;
   logic signed [MUL_W-1:0]   mag_ff;
   side_type                  side_out_ff;

   assign xe_in = VEC_W'(in_x);
   assign ye_in = VEC_W'(in_y);

   // fold the left half plane over before the first iteration
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= in_x[DATA_W-1] ? -xe_in : xe_in;
         y_ff[0]    <= in_x[DATA_W-1] ? -ye_in : ye_in;
         z_ff[0]    <= in_x[DATA_W-1] ? HALF_TURN : '0;
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i][VEC_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_at(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_at(i);
            end
            zero_ff[i+1] <= zero_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[N-1:0], in_valid};
         vld_out_ff <= vld_ff[N];
      end
   end

   // remove the CORDIC gain; x is never negative here
   assign mag_prod = x_ff[N][VEC_W-2:0] * GAIN_Q;
   assign mag_in   = MUL_W'((mag_prod + (PW'(1) << (FRAC_BITS-1))) >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff      <= zero_ff[N] ? '0 : z_ff[N];
         mag_ff      <= zero_ff[N] ? '0 : mag_in;
         side_out_ff <= side_ff[N];
      end
   end

   assign out_valid = vld_out_ff;
   assign out_ang   = ang_ff;
   assign out_mag   = mag_ff;
   assign out_side  = side_out_ff;

endmodule

`default_nettype wire

[hw/rtl/drrm_rot_cordic.sv]
// Rotation CORDIC pipeline: cosine and sine of a binary angle.
`default_nettype none

module drrm_rot_cordic
   import drrm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic [ANG_W-1:0]         in_ang,
   output logic signed [DATA_W-1:0]      out_cos,
   output logic signed [DATA_W-1:0]      out_sin
);

   localparam int N = CORDIC_STAGES;

   logic                    flip_ff [N+1];
   logic signed [ROT_W-1:0] x_ff    [N+1];
   logic signed [ROT_W-1:0] y_ff    [N+1];
   logic [ANG_W-1:0]        z_ff    [N+1];
   logic                    flip_in;
   logic [ANG_W-1:0]        sum_in;

   assign sum_in  = in_ang + QUARTER_TURN;
   assign flip_in = sum_in[ANG_W-1];

   // fold the back half turn onto the front one
   always_ff @(posedge clock) begin
      if (en) begin
         flip_ff[0] <= flip_in;
         z_ff[0]    <= flip_in ? in_ang - HALF_TURN : in_ang;
         x_ff[0]    <= $signed({{(ROT_W-GAIN_W){1'b0}}, GAIN_Q});
         y_ff[0]    <= '0;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [ROT_W-1:0] xs;
      logic signed [ROT_W-1:0] ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][ANG_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_at(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_at(i);
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign out_cos = DATA_W'(flip_ff[N] ? -x_ff[N] : x_ff[N]);
   assign out_sin = DATA_W'(flip_ff[N] ? -y_ff[N] : y_ff[N]);

endmodule

`default_nettype wire

[hw/rtl/drrm_mat.sv]
// Matrix assembly: two product stages, then sums with saturation into the output register.
`default_nettype none

module drrm_mat
   import drrm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [DATA_W-1:0] in_cp,
   input  wire logic signed [DATA_W-1:0] in_sp,
   input  wire logic signed [MUL_W-1:0]  in_st,
   input  wire logic signed [DATA_W-1:0] in_ct,
   input  wire logic signed [DATA_W-1:0] in_co,
   input  wire logic signed [DATA_W-1:0] in_so,
   output logic                          out_valid,
   output logic [MAT_W-1:0]              out_data
);

   logic                    v1_ff;
   logic                    v2_ff;
   logic                    vo_ff;

   logic signed [PRD_W-1:0] cpct_ff, spct_ff, sps1_ff, spc1_ff, cps1_ff, cpc1_ff;
   logic signed [PRD_W-1:0] cpst1_ff, spst1_ff, stco1_ff, stso1_ff;
   logic signed [DATA_W-1:0] co1_ff, so1_ff, ct1_ff, ct2_ff;

   logic signed [PRD_W-1:0] a00_ff, a01_ff, a10_ff, a11_ff;
   logic signed [PRD_W-1:0] sps2_ff, spc2_ff, cps2_ff, cpc2_ff;
   logic signed [PRD_W-1:0] cpst2_ff, spst2_ff, stco2_ff, stso2_ff;

   logic [MAT_W-1:0]        mat_ff;
   logic [MAT_W-1:0]        mat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         vo_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpct_ff  <= mulq(MUL_W'(in_cp), MUL_W'(in_ct));
         spct_ff  <= mulq(MUL_W'(in_sp), MUL_W'(in_ct));
         sps1_ff  <= mulq(MUL_W'(in_sp), MUL_W'(in_so));
         spc1_ff  <= mulq(MUL_W'(in_sp), MUL_W'(in_co));
         cps1_ff  <= mulq(MUL_W'(in_cp), MUL_W'(in_so));
         cpc1_ff  <= mulq(MUL_W'(in_cp), MUL_W'(in_co));
         cpst1_ff <= mulq(MUL_W'(in_cp), in_st);
         spst1_ff <= mulq(MUL_W'(in_sp), in_st);
         stco1_ff <= mulq(in_st, MUL_W'(in_co));
         stso1_ff <= mulq(in_st, MUL_W'(in_so));
         co1_ff   <= in_co;
         so1_ff   <= in_so;
         ct1_ff   <= in_ct;

         a00_ff   <= mulq(MUL_W'(cpct_ff), MUL_W'(co1_ff));
         a01_ff   <= mulq(MUL_W'(cpct_ff), MUL_W'(so1_ff));
         a10_ff   <= mulq(MUL_W'(spct_ff), MUL_W'(co1_ff));
         a11_ff   <= mulq(MUL_W'(spct_ff), MUL_W'(so1_ff));
         sps2_ff  <= sps1_ff;
         spc2_ff  <= spc1_ff;
         cps2_ff  <= cps1_ff;
         cpc2_ff  <= cpc1_ff;
         cpst2_ff <= cpst1_ff;
         spst2_ff <= spst1_ff;
         stco2_ff <= stco1_ff;
         stso2_ff <= stso1_ff;
         ct2_ff   <= ct1_ff;

         mat_ff   <= mat_in;
      end
   end

   always_comb begin
      mat_in[0*DATA_W +: DATA_W] = sat_q30((PRD_W+1)'(a00_ff) - (PRD_W+1)'(sps2_ff));
      mat_in[1*DATA_W +: DATA_W] = sat_q30(-(PRD_W+1)'(a01_ff) - (PRD_W+1)'(spc2_ff));
      mat_in[2*DATA_W +: DATA_W] = sat_q30((PRD_W+1)'(cpst2_ff));
      mat_in[3*DATA_W +: DATA_W] = sat_q30((PRD_W+1)'(a10_ff) + (PRD_W+1)'(cps2_ff));
      mat_in[4*DATA_W +: DATA_W] = sat_q30(-(PRD_W+1)'(a11_ff) + (PRD_W+1)'(cpc2_ff));
      mat_in[5*DATA_W +: DATA_W] = sat_q30((PRD_W+1)'(spst2_ff));
      mat_in[6*DATA_W +: DATA_W] = sat_q30(-(PRD_W+1)'(stco2_ff));
      mat_in[7*DATA_W +: DATA_W] = sat_q30((PRD_W+1)'(stso2_ff));
      mat_in[8*DATA_W +: DATA_W] = sat_q30((PRD_W+1)'(ct2_ff));
   end

   assign out_valid = vo_ff;
   assign out_data  = mat_ff;

endmodule

`default_nettype wire
